/* rtl/core/crs_pkg.sv */
// shared types, constants and gf(2^8) helpers for the cauchy rs parity encoder
package crs_pkg;

    localparam int MAX_DATA_BLOCKS   = 16;
    localparam int MAX_PARITY_BLOCKS = 8;

    localparam int BYTE_W   = 8;
    localparam int BIDX_W   = 4;
    localparam int PIDX_W   = 3;
    localparam int DCNT_W   = 5;
    localparam int PCNT_W   = 4;
    localparam int COEF_W   = 5;
    localparam int COEF_N   = 1 << COEF_W;

    // field polynomial 0x11d, the top bit drops out of an 8-bit shift
    localparam logic [8:0] GF_POLY = 9'h11D;
    localparam logic [8:0] GF_TOP  = 9'h100;

    // register indexes of the configuration port
    localparam logic REG_DATA_COUNT   = 1'b0;
    localparam logic REG_PARITY_COUNT = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COEF_N-1:0][BYTE_W-1:0] inv_table_t;

    // clamped configuration seen by front and back
    typedef struct packed {
        logic [DCNT_W-1:0] eff_data;
        logic [PCNT_W-1:0] eff_parity;
    } crs_cfg_t;

    // one classified item: products for every parity lane
    typedef struct packed {
        logic                                    col_end;
        logic [MAX_PARITY_BLOCKS-1:0][BYTE_W-1:0] prod;
    } crs_entry_t;

    // carry-less multiply reduced by the field polynomial
    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] r;
        x = a;
        r = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i]) begin
                r = r ^ x;
            end
            if (x[BYTE_W-1]) begin
                x = (x << 1) ^ GF_POLY[BYTE_W-1:0];
            end else begin
                x = x << 1;
            end
        end
        return r;
    endfunction

    // inverse table over the small coefficient range, built at elaboration
    function automatic inv_table_t gf_build_inv_table();
        inv_table_t        t;
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] e;
        for (int a = 0; a < COEF_N; a++) begin
            r    = 8'd1;
            base = BYTE_W'(a);
            e    = 8'd254;
            for (int j = 0; j < BYTE_W; j++) begin
                if (e[j]) begin
                    r = gf_mul(r, base);
                end
                base = gf_mul(base, base);
            end
            t[a] = (a == 0) ? '0 : r;
        end
        return t;
    endfunction

    localparam inv_table_t GF_INV_TABLE = gf_build_inv_table();

endpackage

/* rtl/core/crs_front.sv */
// front stage: takes input items, checks the block index, forms lane products
module crs_front
    import crs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  crs_cfg_t            cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [BIDX_W-1:0]   block_index,
    input  logic                column_end,
    output logic                q_valid,
    input  logic                q_ready,
    output crs_entry_t          q_entry
);

    logic       stage_valid_reg;
    crs_entry_t stage_entry_reg;
    crs_entry_t entry_next;
    logic       hit;
    logic [COEF_W-1:0] col_sum;
    logic [COEF_W-1:0] coef_idx [MAX_PARITY_BLOCKS];

    assign s_tready = !stage_valid_reg || q_ready;
    assign q_valid  = stage_valid_reg;
    assign q_entry  = stage_entry_reg;

    // in range bytes feed every active lane with coefficient 1/(k ^ (idx + p))
    always_comb begin
        hit     = ({1'b0, block_index} < cfg.eff_data);
        col_sum = COEF_W'(block_index) + COEF_W'(cfg.eff_parity);
        entry_next.col_end = column_end;
        for (int k = 0; k < MAX_PARITY_BLOCKS; k++) begin
            coef_idx[k] = COEF_W'(k) ^ col_sum;
            if (hit && (PCNT_W'(k) < cfg.eff_parity)) begin
                entry_next.prod[k] = gf_mul(GF_INV_TABLE[coef_idx[k]], data_byte);
            end else begin
                entry_next.prod[k] = '0;
            end
        end
    end

    // stage register, refilled while the queue drains it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            stage_valid_reg <= 1'b1;
        end else if (q_ready) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            stage_entry_reg <= entry_next;
        end
    end

endmodule

/* rtl/core/crs_queue.sv */
// short item queue between front and back
module crs_queue
    import crs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  crs_entry_t in_entry,
    output logic       out_valid,
    input  logic       out_ready,
    output crs_entry_t out_entry
);

    crs_entry_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = mem[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= in_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

/* rtl/core/crs_back.sv */
// back end: parity accumulators and the parity emitter
module crs_back
    import crs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  crs_cfg_t            cfg,
    input  logic                q_valid,
    output logic                q_ready,
    input  crs_entry_t          q_entry,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [BYTE_W-1:0]   parity_byte,
    output logic [PIDX_W-1:0]   parity_index,
    output logic                last
);

    logic [BYTE_W-1:0] acc_reg    [MAX_PARITY_BLOCKS];
    logic [BYTE_W-1:0] acc_sum    [MAX_PARITY_BLOCKS];
    logic [BYTE_W-1:0] shadow_reg [MAX_PARITY_BLOCKS];
    logic              busy_reg;
    logic [PIDX_W-1:0] pidx_reg;
    logic              pop;
    logic              emit;

    // a column end waits until the previous column is fully sent
    assign q_ready = !(q_entry.col_end && busy_reg);
    assign pop     = q_valid && q_ready;
    assign emit    = busy_reg && m_tready;

    assign m_tvalid     = busy_reg;
    assign parity_byte  = shadow_reg[0];
    assign parity_index = pidx_reg;
    assign last         = ({1'b0, pidx_reg} == (cfg.eff_parity - PCNT_W'(1)));

    always_comb begin
        for (int k = 0; k < MAX_PARITY_BLOCKS; k++) begin
            acc_sum[k] = acc_reg[k] ^ q_entry.prod[k];
        end
    end

    // accumulate, cleared after the column end item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_PARITY_BLOCKS; k++) begin
                acc_reg[k] <= '0;
            end
        end else if (pop) begin
            for (int k = 0; k < MAX_PARITY_BLOCKS; k++) begin
                acc_reg[k] <= q_entry.col_end ? '0 : acc_sum[k];
            end
        end
    end

    // emitter control: load on column end, count parity items out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pidx_reg <= '0;
        end else if (pop && q_entry.col_end) begin
            busy_reg <= (cfg.eff_parity != '0);
            pidx_reg <= '0;
        end else if (emit) begin
            if (last) begin
                busy_reg <= 1'b0;
            end
            pidx_reg <= pidx_reg + PIDX_W'(1);
        end
    end

    // shadow copy shifts toward the output slot
    always_ff @(posedge aclk) begin
        if (pop && q_entry.col_end) begin
            for (int k = 0; k < MAX_PARITY_BLOCKS; k++) begin
                shadow_reg[k] <= acc_sum[k];
            end
        end else if (emit) begin
            for (int k = 0; k < MAX_PARITY_BLOCKS - 1; k++) begin
                shadow_reg[k] <= shadow_reg[k+1];
            end
            shadow_reg[MAX_PARITY_BLOCKS-1] <= '0;
        end
    end

endmodule

/* rtl/core/cauchy_rs_parity_encoder_core.sv */
// top level of the cauchy reed-solomon gf(2^8) parity encoder
// Usage:
//   s_ channel carries one data byte per item with its data block index;
//   s_tlast marks the last byte of a column. For each column the m_ channel
//   returns parity_count parity bytes, parity block 0 first, m_tlast on the
//   final one. Bytes whose block index is at or above data_count add nothing.
//   cfg_ writes set data_count (index 0) and parity_count (index 1); write
//   them only while no item is in flight. cfg_ready is always high.
// Throughput: one input item per cycle while s_tready is high, set by the
//   front product stage and the back accumulators which each take one item
//   per cycle. Parity of one column streams out while the next column is
//   taken in; a column end item waits in the queue until the previous
//   column's last parity byte has gone out, so a column end item never
//   leaves the queue while the parity emitter is busy.
// Output: an accepted column end item passes the front stage register and the
//   queue, then the back loads its shadow copy and emits one parity byte per cycle while m_tready is high.
// Reset: accumulators clear, data_count and parity_count return to 1.
// A stalled m_ side holds the current parity byte; once the next column end
//   item reaches the head of the four entry queue, the items behind it fill
//   the queue and the front stage, and s_tready drops.
module cauchy_rs_parity_encoder_core
    import crs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], block_index[11:8], zero pad
    input  logic        s_tlast,   // column_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // parity_byte[7:0], parity_index[10:8], zero pad
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);

    logic [DCNT_W-1:0] data_count_reg;
    logic [PCNT_W-1:0] parity_count_reg;
    crs_cfg_t          cfg;
    logic              q_in_valid;
    logic              q_in_ready;
    crs_entry_t        q_in_entry;
    logic              q_out_valid;
    logic              q_out_ready;
    crs_entry_t        q_out_entry;
    logic [BYTE_W-1:0] parity_byte;
    logic [PIDX_W-1:0] parity_index;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_count_reg   <= DCNT_W'(1);
            parity_count_reg <= PCNT_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DATA_COUNT:   data_count_reg   <= cfg_data[DCNT_W-1:0];
                REG_PARITY_COUNT: parity_count_reg <= cfg_data[PCNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamp to the supported block counts
    always_comb begin
        cfg.eff_data   = (data_count_reg > DCNT_W'(MAX_DATA_BLOCKS)) ?
                         DCNT_W'(MAX_DATA_BLOCKS) : data_count_reg;
        cfg.eff_parity = (parity_count_reg > PCNT_W'(MAX_PARITY_BLOCKS)) ?
                         PCNT_W'(MAX_PARITY_BLOCKS) : parity_count_reg;
    end

    crs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .data_byte   (s_tdata[7:0]),
        .block_index (s_tdata[11:8]),
        .column_end  (s_tlast),
        .q_valid     (q_in_valid),
        .q_ready     (q_in_ready),
        .q_entry     (q_in_entry)
    );

    crs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_entry  (q_in_entry),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_entry (q_out_entry)
    );

    crs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .q_valid      (q_out_valid),
        .q_ready      (q_out_ready),
        .q_entry      (q_out_entry),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .parity_byte  (parity_byte),
        .parity_index (parity_index),
        .last         (m_tlast)
    );

    assign m_tdata = {5'b0, parity_index, parity_byte};

    // parity index stays within the active parity count
    a_pidx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[10:8]} < cfg.eff_parity))
        else $error("parity index beyond parity count");

    // the emitter goes quiet right after the final parity item
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("parity emitter still busy after last item");

    // a column end item never leaves the queue while parity is going out
    a_end_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_out_valid && q_out_ready && q_out_entry.col_end) |-> !m_tvalid)
        else $error("column end taken while previous column still emitting");

endmodule

/* sim/crs_parity_checker.sv */
// scoreboard for the cauchy rs parity encoder: predicts parity items and compares them
module crs_parity_checker
    import crs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], block_index[11:8], zero pad
    input  logic        s_tlast,   // column_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // parity_byte[7:0], parity_index[10:8], zero pad
    input  logic        m_tlast,   // last
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    output int          mismatch_count,
    output int          parity_pending
);

    typedef struct {
        logic [BYTE_W-1:0] parity_byte;
        logic [PIDX_W-1:0] parity_index;
        logic              last;
    } parity_item_t;

    parity_item_t      parity_q[$];
    parity_item_t      want;
    logic [BYTE_W-1:0] lane_acc[MAX_PARITY_BLOCKS];
    logic [DCNT_W-1:0] data_count_reg   = 1;
    logic [PCNT_W-1:0] parity_count_reg = 1;
    int                errors = 0;

    // shift-and-add multiply, reducing whenever bit 8 appears
    function automatic logic [BYTE_W-1:0] field_mul(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0]   sh;
        logic [BYTE_W-1:0] prod;
        sh   = {1'b0, a};
        prod = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i]) begin
                prod = prod ^ sh[BYTE_W-1:0];
            end
            sh = sh << 1;
            if (sh[BYTE_W]) begin
                sh = sh ^ GF_POLY;
            end
        end
        return prod;
    endfunction

    // inverse by search over the field; zero maps to zero
    function automatic logic [BYTE_W-1:0] field_inverse(input logic [BYTE_W-1:0] a);
        logic [BYTE_W-1:0] found;
        found = '0;
        for (int b = 1; b < 256; b++) begin
            if (field_mul(a, BYTE_W'(b)) == 8'd1) begin
                found = BYTE_W'(b);
            end
        end
        return found;
    endfunction

    // fold one data byte into the parity lanes, flush them on column end
    task automatic absorb_item(input logic [BYTE_W-1:0] data_byte,
                               input logic [BIDX_W-1:0] block_index,
                               input logic              column_end);
        int                n_par;
        int                n_dat;
        logic [BYTE_W-1:0] base;
        parity_item_t      beat;
        n_par = (parity_count_reg > MAX_PARITY_BLOCKS) ? MAX_PARITY_BLOCKS
                                                       : int'(parity_count_reg);
        n_dat = (data_count_reg > MAX_DATA_BLOCKS) ? MAX_DATA_BLOCKS : int'(data_count_reg);
        if (int'(block_index) < n_dat) begin
            for (int k = 0; k < n_par; k++) begin
                base        = BYTE_W'(k ^ (int'(block_index) + n_par));
                lane_acc[k] = lane_acc[k] ^ field_mul(field_inverse(base), data_byte);
            end
        end
        if (column_end) begin
            for (int k = 0; k < n_par; k++) begin
                beat.parity_byte  = lane_acc[k];
                beat.parity_index = PIDX_W'(k);
                beat.last         = (k + 1 == n_par);
                parity_q.insert(parity_q.size(), beat);
            end
            foreach (lane_acc[k]) lane_acc[k] = '0;
        end
    endtask

    // watch all three channels at each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            parity_q.delete();
            foreach (lane_acc[k]) lane_acc[k] = '0;
            data_count_reg   = 1;
            parity_count_reg = 1;
        end else begin
            // parity item out
            if (m_tvalid && m_tready) begin
                if (parity_q.size() == 0) begin
                    $error("parity item with none expected: parity_byte %0h parity_index %0d",
                           m_tdata[7:0], m_tdata[10:8]);
                    errors++;
                end else begin
                    want = parity_q.pop_front();
                    if (m_tdata[7:0] !== want.parity_byte) begin
                        $error("parity_byte: expected %0h, actual %0h",
                               want.parity_byte, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[10:8] !== want.parity_index) begin
                        $error("parity_index: expected %0d, actual %0d",
                               want.parity_index, m_tdata[10:8]);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            // register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DATA_COUNT) begin
                    data_count_reg = cfg_data;
                end else if (cfg_index == REG_PARITY_COUNT) begin
                    parity_count_reg = cfg_data[PCNT_W-1:0];
                end
            end
            // data item in
            if (s_tvalid && s_tready) begin
                absorb_item(s_tdata[7:0], s_tdata[11:8], s_tlast);
            end
        end
        mismatch_count <= errors;
        parity_pending <= parity_q.size();
    end

endmodule

/* sim/tb_cauchy_rs_parity_encoder_core.sv */
// testbench top: stimulus, configuration and verdict for the cauchy rs parity encoder
module tb_cauchy_rs_parity_encoder_core
    import crs_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_ITEMS   = 28;
    localparam int RANDOM_PHASES = 7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = REG_DATA_COUNT;
    logic [4:0]  cfg_data  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_ready;

    int          mismatch_count;
    int          parity_pending;
    int          cycle_count  = 0;
    int          cur_eff_data = 1;
    bit          sender_gaps  = 1'b1;
    bit          sink_stalls  = 1'b1;

    cauchy_rs_parity_encoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    crs_parity_checker parity_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .parity_pending (parity_pending)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // parity sink: random stall bursts between ready runs
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (sink_stalls && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    end

    // one data item; valid stays high on return so back-to-back items need no gap
    task automatic send_item(input logic [7:0] data_byte, input logic [3:0] block_index,
                             input logic column_end);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, block_index, data_byte};
        s_tlast  <= column_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending and wait for every outstanding parity item
    task automatic drain_columns();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (parity_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write both counts back to back
    task automatic set_config(input logic [4:0] data_count, input logic [4:0] parity_count);
        cfg_valid <= 1'b1;
        cfg_index <= REG_DATA_COUNT;
        cfg_data  <= data_count;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= REG_PARITY_COUNT;
        cfg_data  <= parity_count;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid    <= 1'b0;
        cur_eff_data = (data_count > MAX_DATA_BLOCKS) ? MAX_DATA_BLOCKS : int'(data_count);
    endtask

    // one column of random bytes, mostly valid block indexes, column end on the last
    task automatic send_column(input int len);
        logic [3:0] block_index;
        for (int j = 0; j < len; j++) begin
            if (cur_eff_data == 0 || $urandom_range(0, 9) == 0) begin
                block_index = 4'($urandom_range(0, 15));
            end else begin
                block_index = 4'($urandom_range(0, cur_eff_data - 1));
            end
            send_item(8'($urandom_range(0, 255)), block_index, j == len - 1);
        end
    endtask

    // stimulus and verdict
    initial begin
        int          count;
        int          len;
        logic [4:0]  dc;
        logic [4:0]  pc;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset counts: one data block, one parity block
        send_item(8'hFF, 4'd0, 1'b1);
        send_item(8'h5A, 4'd1, 1'b1);   // index past the data count, column end still flushes
        drain_columns();

        // full size stripe
        set_config(5'd16, 5'd8);
        send_item(8'h80, 4'd15, 1'b0);
        send_item(8'h01, 4'd0, 1'b0);
        send_item(8'hFF, 4'd7, 1'b1);
        drain_columns();

        // both counts above their maximum, clamped
        set_config(5'd31, 5'd15);
        send_item(8'hA5, 4'd15, 1'b0);
        send_item(8'h3C, 4'd9, 1'b1);
        drain_columns();

        // zero data count: every byte dropped, parity comes back zero
        set_config(5'd0, 5'd3);
        send_item(8'hFF, 4'd0, 1'b1);
        drain_columns();

        // zero parity count: nothing comes back
        set_config(5'd5, 5'd0);
        send_item(8'h77, 4'd2, 1'b0);
        send_item(8'h11, 4'd3, 1'b1);
        drain_columns();

        // edge of the data count; bit 4 of the parity write falls away
        set_config(5'd5, 5'd19);
        send_item(8'h01, 4'd4, 1'b0);
        send_item(8'h02, 4'd5, 1'b1);
        drain_columns();

        // random columns under a new setting per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    dc = 5'd16;
                    pc = 5'd8;
                end
                1: begin
                    dc = 5'd1;
                    pc = 5'd1;
                end
                2: begin
                    dc = 5'd16;
                    pc = 5'd1;
                end
                3: begin
                    dc = 5'd1;
                    pc = 5'd8;
                end
                default: begin
                    dc = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(1, 16));
                    pc = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(1, 8));
                end
            endcase
            // last phase runs at full rate on both sides
            if (ph == RANDOM_PHASES - 1) begin
                sender_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            set_config(dc, pc);
            count = 0;
            while (count < PHASE_ITEMS) begin
                len = $urandom_range(1, ((cur_eff_data > 0) ? cur_eff_data : 1) + 2);
                send_column(len);
                count += len;
            end
            drain_columns();
        end

        if (mismatch_count == 0 && parity_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
